// File: hw/rtl/sse_pkg.sv
`default_nettype none
package sse_pkg;

    localparam int MEAS_W     = 24;
    localparam int TIME_W     = 32;
    localparam int MEAN_W     = 32;
    localparam int CHANGE_W   = 33;
    localparam int THR_W      = 24;
    localparam int NOISE_W    = 32;
    localparam int MINS_W     = 6;
    localparam int MCOUNT_W   = 16;
    localparam int PROD_W     = 49;
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 17;
    localparam int QUOT_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 2'd2;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_HEADER   = 2'd1;
    localparam logic [1:0] ST_CAPTURED = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DIVSTART,
        S_DIV,
        S_NONE,
        S_DROP,
        S_HDR,
        S_FETCH,
        S_CAP
    } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/sse_divider.sv
`default_nettype none
module sse_divider
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [sse_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [sse_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                  done,
    output logic [sse_pkg::QUOT_W-1:0]            quotient
);

    localparam int REM_W = sse_pkg::DIVISOR_W + 1;
    localparam int CNT_W = $clog2(sse_pkg::QUOT_W);

    logic [REM_W-1:0]           rem_reg;
    logic [sse_pkg::QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]           step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [REM_W-1:0]           shifted;
    logic                       fits;

    // The quotient is known to fit in QUOT_W bits, so the upper dividend bits
    // already sit below the divisor and seed the remainder directly.
    assign shifted = {rem_reg[REM_W-2:0], quot_reg[sse_pkg::QUOT_W-1]};
    assign fits    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == CNT_W'(sse_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= REM_W'(dividend[sse_pkg::DIVIDEND_W-1:sse_pkg::QUOT_W]);
            quot_reg <= dividend[sse_pkg::QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (shifted - {1'b0, divisor}) : shifted;
            quot_reg <= {quot_reg[sse_pkg::QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// File: hw/rtl/sse_capture_mem.sv
`default_nettype none
module sse_capture_mem
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [AW-1:0]                     waddr,
    input  wire logic signed [sse_pkg::MEAS_W-1:0] wdata,
    input  wire logic [AW-1:0]                     raddr,
    output logic signed [sse_pkg::MEAS_W-1:0]      rdata
);

    logic signed [sse_pkg::MEAS_W-1:0] mem [DEPTH];
    logic signed [sse_pkg::MEAS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/steady_state_edge_detector.sv
`default_nettype none
// Channel  | Direction | Handshake         | Payload
// input    | in        | in_valid/in_stall | action, sample_time, measurement
// output   | out       | out_valid/out_stall | status .. last
// config   | in        | cfg_write         | cfg_index, cfg_data
//
// A start item is evaluated and then waits for the output; a sample that is kept
// also runs the 32-step serial divider for the running mean, and each captured
// sample emitted takes a memory read (S_FETCH) and an output load (S_CAP).
// rst_n clears all control and detector state asynchronously; the capture
// memory is not cleared, and entries are only read after being written.
// A stalled output holds its item; the block waits in its emit state meanwhile.
module steady_state_edge_detector
#(
    parameter int MAX_SAMPLES = 32
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [sse_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sse_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  action,
    input  wire logic [sse_pkg::TIME_W-1:0]            sample_time,
    input  wire logic signed [sse_pkg::MEAS_W-1:0]     measurement,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [1:0]                                 status,
    output logic [sse_pkg::TIME_W-1:0]                 start_time,
    output logic [sse_pkg::TIME_W-1:0]                 end_time,
    output logic signed [sse_pkg::CHANGE_W-1:0]        power_change,
    output logic signed [sse_pkg::MEAS_W-1:0]          captured_value,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]           captured_count,
    output logic                                       last
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int MW    = sse_pkg::MEAS_W;
    localparam int TW    = sse_pkg::TIME_W;

    sse_pkg::state_t state_reg, state_next;

    logic                               action_reg;
    logic [TW-1:0]                      time_reg;
    logic signed [MW-1:0]               meas_reg;

    logic [sse_pkg::THR_W-1:0]          thr_reg;
    logic [sse_pkg::NOISE_W-1:0]        noise_reg;
    logic [sse_pkg::MINS_W-1:0]         mins_reg;

    logic signed [MW-1:0]               prev_meas_reg;
    logic [TW-1:0]                      prev_time_reg;
    logic signed [sse_pkg::MEAN_W-1:0]  mean_reg;
    logic signed [sse_pkg::MEAN_W-1:0]  level_reg;
    logic [sse_pkg::MCOUNT_W-1:0]       mcount_reg;
    logic                               in_tr_reg;
    logic [TW-1:0]                      cap_start_reg;
    logic [TW-1:0]                      cap_end_reg;
    logic [CNT_W-1:0]                   cap_len_reg;
    logic [MAX_SAMPLES-1:0]             hist_reg;
    logic [CNT_W-1:0]                   hist_len_reg;

    logic signed [sse_pkg::PROD_W-1:0]  prod_reg;
    logic [sse_pkg::DIVISOR_W-1:0]      divisor_reg;
    logic                               neg_reg;

    logic                               hdr_flag_reg;
    logic [TW-1:0]                      hdr_start_reg;
    logic [TW-1:0]                      hdr_end_reg;
    logic signed [sse_pkg::CHANGE_W-1:0] hdr_change_reg;
    logic [CNT_W-1:0]                   hdr_len_reg;
    logic [CNT_W-1:0]                   rd_idx_reg;

    logic                               out_valid_reg;
    logic [1:0]                         status_reg;
    logic [TW-1:0]                      start_time_reg;
    logic [TW-1:0]                      end_time_reg;
    logic signed [sse_pkg::CHANGE_W-1:0] power_change_reg;
    logic signed [MW-1:0]               captured_value_reg;
    logic [CNT_W-1:0]                   captured_count_reg;
    logic                               last_reg;

    // Evaluation of one sample.
    logic signed [MW:0]                 diff;
    logic [MW:0]                        adiff;
    logic                               jump;
    logic                               want_cap;
    logic                               full;
    logic                               drop;
    logic [CNT_W-1:0]                   cap_len_a;
    logic [TW-1:0]                      cap_start_a;
    logic [TW-1:0]                      cap_end_a;
    logic [CNT_W-1:0]                   n_lim;
    logic [MAX_SAMPLES-1:0]             hist_sh;
    logic [MAX_SAMPLES-1:0]             hist_a;
    logic [MAX_SAMPLES-1:0]             hist_mask;
    logic [CNT_W-1:0]                   hist_len_a;
    logic                               steady;
    logic signed [sse_pkg::CHANGE_W-1:0] lt;
    logic [sse_pkg::CHANGE_W-1:0]       lt_mag;
    logic                               report;

    logic signed [sse_pkg::PROD_W-1:0]  num;
    logic [sse_pkg::PROD_W-1:0]         num_mag;
    logic                               div_start;
    logic                               div_done;
    logic [sse_pkg::QUOT_W-1:0]         div_quot;

    logic                               mem_we;
    logic signed [MW-1:0]               mem_rdata;

    logic                               out_free;
    logic                               out_load;
    logic [1:0]                         ld_status;
    logic [TW-1:0]                      ld_start;
    logic [TW-1:0]                      ld_end;
    logic signed [sse_pkg::CHANGE_W-1:0] ld_change;
    logic signed [MW-1:0]               ld_value;
    logic [CNT_W-1:0]                   ld_count;
    logic                               ld_last;
    logic                               cap_final;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cap_final = (rd_idx_reg + 1'b1) == hdr_len_reg;

    always_comb
    begin
        diff  = {meas_reg[MW-1], meas_reg} - {prev_meas_reg[MW-1], prev_meas_reg};
        adiff = diff[MW] ? (MW+1)'(-diff) : diff;
        jump  = adiff > {1'b0, thr_reg};

        want_cap    = in_tr_reg || jump;
        full        = cap_len_reg >= CNT_W'(MAX_SAMPLES);
        drop        = want_cap && full;
        cap_len_a   = want_cap ? cap_len_reg + 1'b1 : cap_len_reg;
        cap_start_a = (!in_tr_reg && jump && (cap_len_reg == '0)) ? prev_time_reg
                                                                  : cap_start_reg;
        cap_end_a   = (in_tr_reg && !jump) ? prev_time_reg : cap_end_reg;

        // A minimum above the history depth acts as the full depth.
        if ({1'b0, mins_reg} > (sse_pkg::MINS_W+1)'(MAX_SAMPLES))
        begin
            n_lim = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            n_lim = CNT_W'(mins_reg);
        end

        hist_sh = hist_reg >> 1;
        for (int i = 0; i < MAX_SAMPLES; i++)
        begin
            hist_mask[i] = i < int'(n_lim);
            if (hist_len_reg < n_lim)
            begin
                hist_a[i] = (i == int'(hist_len_reg)) ? jump : hist_reg[i];
            end
            else if (n_lim != '0)
            begin
                if (i < int'(n_lim) - 1)
                begin
                    hist_a[i] = hist_sh[i];
                end
                else if (i == int'(n_lim) - 1)
                begin
                    hist_a[i] = jump;
                end
                else
                begin
                    hist_a[i] = hist_reg[i];
                end
            end
            else
            begin
                hist_a[i] = hist_reg[i];
            end
        end
        hist_len_a = (hist_len_reg < n_lim) ? hist_len_reg + 1'b1 : hist_len_reg;
        steady     = (hist_len_a == n_lim) && ((hist_a & hist_mask) == '0);

        lt     = {mean_reg[sse_pkg::MEAN_W-1], mean_reg}
               - {level_reg[sse_pkg::MEAN_W-1], level_reg};
        lt_mag = lt[sse_pkg::CHANGE_W-1] ? sse_pkg::CHANGE_W'(-lt) : lt;
        report = steady && (lt_mag > {1'b0, noise_reg});

        num     = prod_reg + sse_pkg::PROD_W'($signed({meas_reg, 8'b0}));
        num_mag = num[sse_pkg::PROD_W-1] ? sse_pkg::PROD_W'(-num) : num;
    end

    assign div_start = state_reg == sse_pkg::S_DIVSTART;
    assign mem_we    = (state_reg == sse_pkg::S_EVAL) && action_reg && want_cap && !full;

    sse_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag[sse_pkg::DIVIDEND_W-1:0]),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    sse_capture_mem
    #(
        .DEPTH (MAX_SAMPLES),
        .AW    (IDX_W)
    )
    u_capture_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cap_len_reg[IDX_W-1:0]),
        .wdata (prev_meas_reg),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sse_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sse_pkg::S_EVAL;
                end
            end
            sse_pkg::S_EVAL:
            begin
                priority if (!action_reg)
                begin
                    state_next = sse_pkg::S_NONE;
                end
                else if (drop)
                begin
                    state_next = sse_pkg::S_DROP;
                end
                else
                begin
                    state_next = sse_pkg::S_DIVSTART;
                end
            end
            sse_pkg::S_DIVSTART:
            begin
                state_next = sse_pkg::S_DIV;
            end
            sse_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = hdr_flag_reg ? sse_pkg::S_HDR : sse_pkg::S_NONE;
                end
            end
            sse_pkg::S_NONE, sse_pkg::S_DROP:
            begin
                if (out_free)
                begin
                    state_next = sse_pkg::S_IDLE;
                end
            end
            sse_pkg::S_HDR:
            begin
                if (out_free)
                begin
                    state_next = (hdr_len_reg == '0) ? sse_pkg::S_IDLE : sse_pkg::S_FETCH;
                end
            end
            sse_pkg::S_FETCH:
            begin
                state_next = sse_pkg::S_CAP;
            end
            sse_pkg::S_CAP:
            begin
                if (out_free)
                begin
                    state_next = cap_final ? sse_pkg::S_IDLE : sse_pkg::S_FETCH;
                end
            end
            default:
            begin
                state_next = sse_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_load  = 1'b0;
        ld_status = sse_pkg::ST_NONE;
        ld_start  = '0;
        ld_end    = '0;
        ld_change = '0;
        ld_value  = '0;
        ld_count  = cap_len_reg;
        ld_last   = 1'b1;
        unique case (state_reg)
            sse_pkg::S_NONE:
            begin
                out_load = out_free;
            end
            sse_pkg::S_DROP:
            begin
                out_load  = out_free;
                ld_status = sse_pkg::ST_DROPPED;
            end
            sse_pkg::S_HDR:
            begin
                out_load  = out_free;
                ld_status = sse_pkg::ST_HEADER;
                ld_start  = hdr_start_reg;
                ld_end    = hdr_end_reg;
                ld_change = hdr_change_reg;
                ld_count  = hdr_len_reg;
                ld_last   = hdr_len_reg == '0;
            end
            sse_pkg::S_CAP:
            begin
                out_load  = out_free;
                ld_status = sse_pkg::ST_CAPTURED;
                ld_value  = mem_rdata;
                ld_count  = hdr_len_reg;
                ld_last   = cap_final;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sse_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= sse_pkg::THR_W'(15);
            noise_reg     <= sse_pkg::NOISE_W'(17920);
            mins_reg      <= sse_pkg::MINS_W'(3);
            prev_meas_reg <= '0;
            prev_time_reg <= '0;
            mean_reg      <= '0;
            level_reg     <= '0;
            mcount_reg    <= '0;
            in_tr_reg     <= 1'b0;
            cap_start_reg <= '0;
            cap_end_reg   <= '0;
            cap_len_reg   <= '0;
            hist_reg      <= '0;
            hist_len_reg  <= '0;
            hdr_flag_reg  <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    sse_pkg::CFG_JUMP_THRESHOLD: thr_reg   <= cfg_data[sse_pkg::THR_W-1:0];
                    sse_pkg::CFG_NOISE_LEVEL:    noise_reg <= cfg_data[sse_pkg::NOISE_W-1:0];
                    sse_pkg::CFG_MIN_SAMPLES:    mins_reg  <= cfg_data[sse_pkg::MINS_W-1:0];
                    default:                     ;
                endcase
            end

            if (state_reg == sse_pkg::S_EVAL)
            begin
                rd_idx_reg <= '0;
                if (!action_reg)
                begin
                    prev_meas_reg <= meas_reg;
                    prev_time_reg <= time_reg;
                    mean_reg      <= '0;
                    level_reg     <= {meas_reg, 8'b0};
                    mcount_reg    <= '0;
                    in_tr_reg     <= 1'b0;
                    cap_start_reg <= '0;
                    cap_end_reg   <= time_reg;
                    cap_len_reg   <= '0;
                    hist_reg      <= '0;
                    hist_len_reg  <= '0;
                    hdr_flag_reg  <= 1'b0;
                end
                else if (!drop)
                begin
                    cap_start_reg <= cap_start_a;
                    cap_end_reg   <= cap_end_a;
                    cap_len_reg   <= report ? '0 : cap_len_a;
                    hist_reg      <= hist_a;
                    hist_len_reg  <= hist_len_a;
                    hdr_flag_reg  <= report;
                    if (steady)
                    begin
                        level_reg <= mean_reg;
                    end
                    if (jump)
                    begin
                        mcount_reg <= '0;
                    end
                    else if (mcount_reg != '1)
                    begin
                        mcount_reg <= mcount_reg + 1'b1;
                    end
                    in_tr_reg     <= jump;
                    prev_meas_reg <= meas_reg;
                    prev_time_reg <= time_reg;
                end
            end

            if ((state_reg == sse_pkg::S_DIV) && div_done)
            begin
                mean_reg <= neg_reg ? -$signed(div_quot) : $signed(div_quot);
            end

            if ((state_reg == sse_pkg::S_CAP) && out_free)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == sse_pkg::S_IDLE) && in_valid)
        begin
            action_reg <= action;
            time_reg   <= sample_time;
            meas_reg   <= measurement;
        end
        if (state_reg == sse_pkg::S_EVAL)
        begin
            prod_reg       <= $signed({1'b0, mcount_reg}) * mean_reg;
            divisor_reg    <= sse_pkg::DIVISOR_W'(mcount_reg) + 1'b1;
            hdr_start_reg  <= (cap_len_a != '0) ? cap_start_a : prev_time_reg;
            hdr_end_reg    <= cap_end_a;
            hdr_change_reg <= lt;
            hdr_len_reg    <= cap_len_a;
        end
        if (state_reg == sse_pkg::S_DIVSTART)
        begin
            neg_reg <= num[sse_pkg::PROD_W-1];
        end
        if (out_load)
        begin
            status_reg         <= ld_status;
            start_time_reg     <= ld_start;
            end_time_reg       <= ld_end;
            power_change_reg   <= ld_change;
            captured_value_reg <= ld_value;
            captured_count_reg <= ld_count;
            last_reg           <= ld_last;
        end
    end

    assign in_stall       = state_reg != sse_pkg::S_IDLE;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign start_time     = start_time_reg;
    assign end_time       = end_time_reg;
    assign power_change   = power_change_reg;
    assign captured_value = captured_value_reg;
    assign captured_count = captured_count_reg;
    assign last           = last_reg;

`ifndef NO_ASSERTIONS
    a_cap_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cap_len_reg <= CNT_W'(MAX_SAMPLES))
        else $error("capture length exceeds the store depth");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sse_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block ready again right after taking an item");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> !out_stall)
        else $error("output overwritten while stalled");
`endif

endmodule
`default_nettype wire

// File: tb/steady_state_edge_detector_tb.sv
module steady_state_edge_detector_tb;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam bit ACT_START = 1'b0;
    localparam bit ACT_SAMPLE = 1'b1;

    typedef struct {
        logic [1:0] status;
        logic [sse_pkg::TIME_W-1:0] start_time;
        logic [sse_pkg::TIME_W-1:0] end_time;
        logic [sse_pkg::CHANGE_W-1:0] power_change;
        logic [sse_pkg::MEAS_W-1:0] captured_value;
        logic [5:0] captured_count;
        logic last;
    } detector_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [sse_pkg::CFG_IDX_W-1:0] cfg_index = sse_pkg::CFG_JUMP_THRESHOLD;
    logic [sse_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = ACT_START;
    logic [sse_pkg::TIME_W-1:0] sample_time = '0;
    logic signed [sse_pkg::MEAS_W-1:0] measurement = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [sse_pkg::TIME_W-1:0] start_time;
    logic [sse_pkg::TIME_W-1:0] end_time;
    logic signed [sse_pkg::CHANGE_W-1:0] power_change;
    logic signed [sse_pkg::MEAS_W-1:0] captured_value;
    logic [5:0] captured_count;
    logic last;

    steady_state_edge_detector DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .sample_time(sample_time), .measurement(measurement),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .start_time(start_time), .end_time(end_time),
        .power_change(power_change), .captured_value(captured_value),
        .captured_count(captured_count), .last(last)
    );

    // Detector state mirrored for prediction.
    longint thr_cfg, noise_cfg, min_cfg;
    longint prev_meas, mean_q8, level_q8;
    int mean_cnt;
    bit in_trans;
    logic [sse_pkg::TIME_W-1:0] cap_start, cap_end, prev_t;
    longint cap_buf [DEPTH];
    int cap_len;
    bit jump_hist [DEPTH];
    int hist_len;

    detector_result_t pending_results[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int headers_seen = 0;
    int drops_seen = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    logic [sse_pkg::TIME_W-1:0] clock_ticks = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_result(logic [1:0] st, logic [31:0] t0, logic [31:0] t1,
                               longint pc, longint cv, int cnt, bit lst);
        detector_result_t r;
        r.status = st;
        r.start_time = t0;
        r.end_time = t1;
        r.power_change = pc[sse_pkg::CHANGE_W-1:0];
        r.captured_value = cv[sse_pkg::MEAS_W-1:0];
        r.captured_count = cnt[5:0];
        r.last = lst;
        pending_results.push_back(r);
    endtask

    task automatic clear_detector();
        prev_meas = 0;
        mean_q8 = 0;
        level_q8 = 0;
        mean_cnt = 0;
        in_trans = 0;
        cap_start = '0;
        cap_end = '0;
        prev_t = '0;
        cap_len = 0;
        hist_len = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            cap_buf[i] = 0;
            jump_hist[i] = 0;
        end
    endtask

    task automatic predict_detector(bit act, logic [31:0] t, logic signed [23:0] m_in);
        longint m, d, lt, mag;
        int n, emitted;
        bit jump, quiet;
        m = m_in;
        n = (min_cfg > DEPTH) ? DEPTH : int'(min_cfg);
        emitted = 0;
        if (act == ACT_START)
        begin
            clear_detector();
            cap_end = t;
            prev_t = t;
            prev_meas = m;
            level_q8 = m * 256;
            push_result(sse_pkg::ST_NONE, 0, 0, 0, 0, 0, 1);
            return;
        end
        d = m - prev_meas;
        if (d < 0)
            d = -d;
        jump = d > thr_cfg;
        if (jump || in_trans)
        begin
            if (!in_trans && cap_len == 0)
                cap_start = prev_t;
            if (cap_len >= DEPTH)
            begin
                push_result(sse_pkg::ST_DROPPED, 0, 0, 0, 0, cap_len, 1);
                return;
            end
            cap_buf[cap_len] = prev_meas;
            cap_len++;
            if (in_trans && !jump)
                cap_end = prev_t;
        end
        if (hist_len < n)
        begin
            jump_hist[hist_len] = jump;
            hist_len++;
        end
        else if (n > 0)
        begin
            for (int i = 0; i < n - 1; i++)
                jump_hist[i] = jump_hist[i + 1];
            jump_hist[n - 1] = jump;
        end
        if (hist_len == n)
        begin
            quiet = 1;
            for (int i = 0; i < hist_len && i < DEPTH; i++)
                if (jump_hist[i])
                    quiet = 0;
            if (quiet)
            begin
                lt = mean_q8 - level_q8;
                mag = (lt < 0) ? -lt : lt;
                if (mag > noise_cfg)
                begin
                    push_result(sse_pkg::ST_HEADER, (cap_len > 0) ? cap_start : prev_t,
                                cap_end, lt, 0, cap_len, cap_len == 0);
                    emitted++;
                    for (int i = 0; i < cap_len; i++)
                        push_result(sse_pkg::ST_CAPTURED, 0, 0, 0, cap_buf[i], cap_len,
                                    i + 1 == cap_len);
                    cap_len = 0;
                end
                level_q8 = mean_q8;
            end
        end
        // Signed division truncates toward zero, as the block does.
        mean_q8 = (longint'(mean_cnt) * mean_q8 + m * 256) / (longint'(mean_cnt) + 1);
        if (jump)
            mean_cnt = 0;
        else if (mean_cnt < 65535)
            mean_cnt++;
        in_trans = jump;
        prev_meas = m;
        prev_t = t;
        if (emitted == 0)
            push_result(sse_pkg::ST_NONE, 0, 0, 0, 0, cap_len, 1);
    endtask

    task automatic check_field(string name, logic [32:0] exp_v, logic [32:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        detector_result_t e;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending: status %0d", status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (e.status == sse_pkg::ST_HEADER)
                    headers_seen++;
                if (e.status == sse_pkg::ST_DROPPED)
                    drops_seen++;
                check_field("status", e.status, status);
                check_field("start_time", e.start_time, start_time);
                check_field("end_time", e.end_time, end_time);
                check_field("power_change", e.power_change, power_change);
                check_field("captured_value", e.captured_value, $unsigned(captured_value));
                check_field("captured_count", e.captured_count, captured_count);
                check_field("last", e.last, last);
            end
        end
    end

    task automatic send_item(bit act, logic [31:0] t, logic signed [23:0] m);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        sample_time <= t;
        measurement <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_detector(act, t, m);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [sse_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            sse_pkg::CFG_JUMP_THRESHOLD: thr_cfg = data[23:0];
            sse_pkg::CFG_NOISE_LEVEL: noise_cfg = data;
            sse_pkg::CFG_MIN_SAMPLES: min_cfg = data[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] thr, logic [31:0] noise, logic [31:0] mins);
        write_reg(sse_pkg::CFG_JUMP_THRESHOLD, thr);
        write_reg(sse_pkg::CFG_NOISE_LEVEL, noise);
        write_reg(sse_pkg::CFG_MIN_SAMPLES, mins);
    endtask

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607)
            return 24'sd8388607;
        if (v < -8388608)
            return -24'sd8388608;
        return v[23:0];
    endfunction

    function automatic logic [31:0] next_tick();
        clock_ticks += $urandom_range(1, 1000);
        return clock_ticks;
    endfunction

    // Quiet stretch, a run of jumps, then a quiet stretch at another level.
    task automatic send_transition(longint lvl0, longint lvl1, int nq0, int nj, int nq1);
        longint spread, amp;
        spread = (thr_cfg / 2 > 1000) ? 1000 : thr_cfg / 2;
        amp = thr_cfg / 2 + 1 + $urandom_range(0, 3000);
        for (int i = 0; i < nq0; i++)
            send_item(ACT_SAMPLE, next_tick(),
                      clamp24(lvl0 + $urandom_range(0, spread) - spread / 2));
        for (int i = 0; i < nj; i++)
            send_item(ACT_SAMPLE, next_tick(), clamp24(lvl1 + ((i % 2) ? amp : -amp)));
        for (int i = 0; i < nq1; i++)
            send_item(ACT_SAMPLE, next_tick(),
                      clamp24(lvl1 + $urandom_range(0, spread) - spread / 2));
    endtask

    function automatic longint pick_level();
        if ($urandom_range(3) == 0)
            return longint'($urandom_range(0, 16000000)) - 8000000;
        return longint'($urandom_range(0, 200000)) - 100000;
    endfunction

    task automatic test_directed();
        send_item(ACT_START, 32'h0, 24'sd0);
        send_item(ACT_SAMPLE, 32'hFFFF_FFFF, 24'sd8388607);
        send_item(ACT_SAMPLE, 32'h1, -24'sd8388608);
        send_item(ACT_SAMPLE, 32'h2, 24'sd0);
        send_item(ACT_SAMPLE, 32'h3, 24'sd5);
        send_item(ACT_SAMPLE, 32'h4, 24'sd3);
        send_item(ACT_SAMPLE, 32'h5, 24'sd4);
        send_item(ACT_START, 32'hAAAA_5555, 24'sd1000);
        clock_ticks = 32'hAAAA_5555;
        send_transition(1000, 5000, 4, 3, 5);
        send_transition(5000, -5000, 0, 1, 4);
    endtask

    task automatic test_capture_full();
        send_item(ACT_START, next_tick(), 24'sd0);
        // Keep jumping past the store depth so later samples are dropped.
        send_transition(0, 200, 0, DEPTH + 3, 4);
    endtask

    task automatic test_config_extremes();
        set_config(0, 0, 0);
        send_item(ACT_START, next_tick(), 24'sd10);
        send_transition(10, 11, 2, 2, 3);
        set_config(24'hFF_FFFF, 32'hFFFF_FFFF, DEPTH);
        send_item(ACT_START, next_tick(), -24'sd8388608);
        send_transition(-8388608, 8388607, 3, 2, 3);
        set_config(40, 256, 63);
        send_item(ACT_START, next_tick(), 24'sd0);
        send_transition(0, 3000, 2, 3, 35);
        set_config(15, 17920, 8);
        send_item(ACT_START, next_tick(), 24'sd0);
        send_transition(0, 0, 6, 0, 0);
        // Shrinking the window below the filled history stalls steady detection.
        write_reg(sse_pkg::CFG_MIN_SAMPLES, 2);
        send_transition(0, 4000, 2, 2, 5);
        set_config(15, 17920, 3);
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_level);
        int target;
        int r;
        send_idle_pct = idle_pct;
        stall_pct = stall_level;
        target = items_sent + n_items;
        send_item(ACT_START, next_tick(), clamp24(pick_level()));
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_item($urandom_range(1), $urandom, $urandom);
            else
            begin
                if (r < 25)
                    send_item(ACT_START, next_tick(), clamp24(pick_level()));
                send_transition(pick_level(), pick_level(), $urandom_range(0, 6),
                                $urandom_range(0, 5), $urandom_range(0, 8));
            end
        end
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        thr_cfg = 15;
        noise_cfg = 17920;
        min_cfg = 3;
        clear_detector();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capture_full();
        test_config_extremes();
        test_random(50, 0, 0);
        test_random(50, 65, 0);
        set_config(60, 0, 1);
        test_random(50, 0, 65);
        set_config(15, 17920, 5);
        test_random(50, 17, 17);
        wait_idle();
        $display("Sent %0d items (starts, samples, noise) over four idle/stall mixes.",
                 items_sent);
        $display("Checked %0d results: %0d transition headers, %0d dropped samples.",
                 results_seen, headers_seen, drops_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: steady_state_edge_detector.f
hw/rtl/sse_pkg.sv
hw/rtl/sse_divider.sv
hw/rtl/sse_capture_mem.sv
hw/rtl/steady_state_edge_detector.sv
tb/steady_state_edge_detector_tb.sv
